// ===== rtl/point_in_polygon_test_core_defines.svh =====
// Assertion macros for the point-in-polygon core.
`ifndef POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int IDX_W        = $clog2(MAX_VERTICES + 1);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1) + 1;
  localparam int EC_W         = 8;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_TEST   = 2'd2;

  localparam logic MODE_EVEN_ODD = 1'b0;
  localparam logic MODE_NONZERO  = 1'b1;

  typedef struct packed {
    logic straddle;
    logic dpos;
    logic up;
    logic down;
  } edge_flags_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    edge_flags_t               fl;
    logic signed [PROD_W-1:0]  m1;
    logic signed [PROD_W-1:0]  m2;
    logic signed [CNT_W-1:0]   cnt;
  } token_t;

  typedef struct packed {
    logic                      adv;
    logic                      mode;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } bcast_t;

  typedef struct packed {
    logic                      en;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } wr_t;

  function automatic logic signed [DIFF_W-1:0] dif(logic signed [COORD_W-1:0] a,
                                                   logic signed [COORD_W-1:0] b);
    logic [DIFF_W-1:0] r;
    r = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return r;
  endfunction

  function automatic logic signed [1:0] edge_delta(edge_flags_t f,
                                                   logic signed [PROD_W-1:0] m1,
                                                   logic signed [PROD_W-1:0] m2);
    logic signed [1:0] d;
    d = 2'sd0;
    if (f.straddle && (f.dpos ? (m1 <= m2) : (m1 >= m2))) d = 2'sd1;
    if (f.up && (m1 > m2)) d = 2'sd1;
    if (f.down && (m1 <= m2)) d = -2'sd1;
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pip_if.sv =====
`default_nettype none
interface pip_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic signed [pip_pkg::COORD_W-1:0] coord_x;
  logic signed [pip_pkg::COORD_W-1:0] coord_y;
  modport source (output valid, func, coord_x, coord_y, input ready);
  modport sink   (input valid, func, coord_x, coord_y, output ready);
endinterface

interface pip_res_if;
  logic                            valid;
  logic                            ready;
  logic                            inside_res;
  logic signed [pip_pkg::EC_W-1:0] edge_count;
  modport source (output valid, inside_res, edge_count, input ready);
  modport sink   (input valid, inside_res, edge_count, output ready);
endinterface

interface pip_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pip_cell.sv =====
`default_nettype none
module pip_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pip_pkg::bcast_t bc,
  input  wire pip_pkg::wr_t    wr,
  input  wire logic            wsel,
  input  wire logic            active,
  input  wire pip_pkg::token_t tin,
  output pip_pkg::token_t      tout
);

  logic signed [pip_pkg::COORD_W-1:0] xc;
  logic signed [pip_pkg::COORD_W-1:0] yc;
  logic signed [pip_pkg::DIFF_W-1:0]  a1, b1, a2, b2;
  logic signed [pip_pkg::PROD_W-1:0]  m1, m2;
  pip_pkg::edge_flags_t               fl;
  logic signed [pip_pkg::CNT_W-1:0]   cnt_next;

  always_ff @(posedge clk) begin
    if (wsel) begin
      xc <= wr.x;
      yc <= wr.y;
    end
  end

  always_comb begin
    fl = '0;
    if (bc.mode == pip_pkg::MODE_NONZERO) begin
      a1 = pip_pkg::dif(xc, tin.prev_x);
      b1 = pip_pkg::dif(bc.py, tin.prev_y);
      a2 = pip_pkg::dif(yc, tin.prev_y);
      b2 = pip_pkg::dif(bc.px, tin.prev_x);
      fl.up   = active && (tin.prev_y <= bc.py) && (yc > bc.py);
      fl.down = active && (tin.prev_y > bc.py) && (yc <= bc.py);
    end else begin
      a1 = pip_pkg::dif(bc.px, xc);
      b1 = pip_pkg::dif(tin.prev_y, yc);
      a2 = pip_pkg::dif(tin.prev_x, xc);
      b2 = pip_pkg::dif(bc.py, yc);
      fl.straddle = active && ((yc >= bc.py) != (tin.prev_y >= bc.py));
      fl.dpos     = tin.prev_y > yc;
    end
    m1 = a1 * b1;
    m2 = a2 * b2;
    cnt_next = tin.cnt + pip_pkg::CNT_W'(pip_pkg::edge_delta(tin.fl, tin.m1, tin.m2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else if (bc.adv) begin
      tout.valid <= tin.valid;
    end
    if (bc.adv) begin
      tout.prev_x <= xc;
      tout.prev_y <= yc;
      tout.fl     <= fl;
      tout.m1     <= m1;
      tout.m2     <= m2;
      tout.cnt    <= cnt_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pip_chain.sv =====
`default_nettype none
module pip_chain (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pip_pkg::bcast_t             bc,
  input  wire pip_pkg::wr_t                wr,
  input  wire logic [pip_pkg::IDX_W-1:0]   count,
  input  wire pip_pkg::token_t             head,
  output pip_pkg::token_t                  tail
);

  pip_pkg::token_t link [0:pip_pkg::MAX_VERTICES];

  assign link[0] = head;
  assign tail    = link[pip_pkg::MAX_VERTICES];

  for (genvar k = 0; k < pip_pkg::MAX_VERTICES; k++) begin : g_cell
    logic wsel;
    logic active;
    assign wsel   = wr.en && (count == pip_pkg::IDX_W'(k));
    assign active = pip_pkg::IDX_W'(k) < count;
    pip_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .bc     (bc),
      .wr     (wr),
      .wsel   (wsel),
      .active (active),
      .tin    (link[k]),
      .tout   (link[k+1])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/point_in_polygon_test_core.sv =====
// Clear and append items do not set busy; the next item is accepted on the following cycle.
// A test item flows through one vertex cell per cycle while the row is not stalled, from the
// head register through MAX_VERTICES cell registers to the output register; busy then clears.
// A waiting result stalls the row when the next one reaches its end; no item is accepted while busy.
// Synchronous reset clears the vertex count, rule_mode and all valid flags;
// vertex storage is not cleared.
`default_nettype none
`include "point_in_polygon_test_core_defines.svh"
module point_in_polygon_test_core (
  input  wire logic  clk,
  input  wire logic  rst,
  pip_cmd_if.sink    cmd,
  pip_res_if.source  res,
  pip_cfg_if.sink    cfg
);

  logic                               rule_mode;
  logic [pip_pkg::IDX_W-1:0]          count;
  logic signed [pip_pkg::COORD_W-1:0] last_x;
  logic signed [pip_pkg::COORD_W-1:0] last_y;
  logic signed [pip_pkg::COORD_W-1:0] px;
  logic signed [pip_pkg::COORD_W-1:0] py;
  logic                               busy;
  logic                               out_valid;
  logic                               out_inside;
  logic signed [pip_pkg::EC_W-1:0]    out_count;
  pip_pkg::token_t                    head;
  pip_pkg::token_t                    tail;
  pip_pkg::bcast_t                    bc;
  pip_pkg::wr_t                       wr;
  logic                               accept;
  logic                               accept_test;
  logic                               adv;
  logic signed [pip_pkg::CNT_W-1:0]   cnt_full;
  logic signed [31:0]                 cnt_wide;
  logic signed [pip_pkg::EC_W-1:0]    cnt_sat;
  logic                               in_poly;

  assign cmd.ready   = !busy;
  assign cfg.ready   = 1'b1;
  assign accept      = cmd.valid && cmd.ready;
  assign accept_test = accept && (cmd.func == pip_pkg::FUNC_TEST);
  assign adv         = !(tail.valid && out_valid && !res.ready);

  assign res.valid      = out_valid;
  assign res.inside_res = out_inside;
  assign res.edge_count = out_count;

  always_comb begin
    wr.en = 1'b0;
    wr.x  = cmd.coord_x;
    wr.y  = cmd.coord_y;
    case (cmd.func)
      pip_pkg::FUNC_APPEND: wr.en = accept && (count < pip_pkg::IDX_W'(pip_pkg::MAX_VERTICES));
      default:              wr.en = 1'b0;
    endcase
  end

  assign bc.adv  = adv;
  assign bc.mode = rule_mode;
  assign bc.px   = px;
  assign bc.py   = py;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      rule_mode <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && (cmd.func == pip_pkg::FUNC_CLEAR)) begin
      count <= '0;
    end else if (wr.en) begin
      count <= count + pip_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      last_x <= cmd.coord_x;
      last_y <= cmd.coord_y;
    end
    if (accept_test) begin
      px <= cmd.coord_x;
      py <= cmd.coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (accept_test) begin
      head.valid <= 1'b1;
    end else if (adv) begin
      head.valid <= 1'b0;
    end
    if (accept_test) begin
      head.prev_x <= last_x;
      head.prev_y <= last_y;
      head.fl     <= '0;
      head.m1     <= '0;
      head.m2     <= '0;
      head.cnt    <= '0;
    end
  end

  pip_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .bc    (bc),
    .wr    (wr),
    .count (count),
    .head  (head),
    .tail  (tail)
  );

  always_comb begin
    cnt_full = tail.cnt + pip_pkg::CNT_W'(pip_pkg::edge_delta(tail.fl, tail.m1, tail.m2));
    cnt_wide = 32'(cnt_full);
    if (cnt_wide > 32'sd127) begin
      cnt_sat = 8'sd127;
    end else if (cnt_wide < -32'sd128) begin
      cnt_sat = -8'sd128;
    end else begin
      cnt_sat = pip_pkg::EC_W'(cnt_wide);
    end
    in_poly = (rule_mode == pip_pkg::MODE_NONZERO) ? (cnt_full != '0) : cnt_full[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (tail.valid && adv) begin
        out_valid <= 1'b1;
        busy      <= 1'b0;
      end else begin
        if (res.ready) out_valid <= 1'b0;
        if (accept_test) busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid && adv) begin
      out_inside <= in_poly;
      out_count  <= cnt_sat;
    end
  end

  `PIP_ASSERT_NOW(a_idle_row_empty, !busy, !head.valid && !tail.valid, "item in row while idle")
  `PIP_ASSERT_NOW(a_result_while_busy, tail.valid && adv, busy, "result without test item")
  `PIP_ASSERT_NOW(a_count_bound, 1'b1, count <= pip_pkg::IDX_W'(pip_pkg::MAX_VERTICES), "count high")
  `PIP_ASSERT_NEXT(a_test_starts, accept_test, busy && head.valid, "test item did not enter row")

endmodule
`default_nettype wire
